FILE: rtl/dlp_pkg.sv
// Package for the DAG longest-path unit.
// Holds the controller state encoding, opcodes and distance constants.
// No dependencies.
`timescale 1ns / 1ps

package dlp_pkg;

  // Request opcodes carried on in_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Stored distances and the saturation limit
  localparam int unsigned DIST_BITS = 22;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam int unsigned OUT_DIST_BITS = 23;
  localparam logic [OUT_DIST_BITS-1:0] DIST_NONE = {OUT_DIST_BITS{1'b1}};

  // Controller states, one-hot
  typedef enum logic [14:0] {
    ST_CLR    = 15'b000000000000001,
    ST_IDLE   = 15'b000000000000010,
    ST_DROOT  = 15'b000000000000100,
    ST_DRD    = 15'b000000000001000,
    ST_DCHK   = 15'b000000000010000,
    ST_DPOP   = 15'b000000000100000,
    ST_RINIT  = 15'b000000001000000,
    ST_RTOPO  = 15'b000000010000000,
    ST_RU     = 15'b000000100000000,
    ST_RDU    = 15'b000001000000000,
    ST_RRD    = 15'b000010000000000,
    ST_RCHK   = 15'b000100000000000,
    ST_ORD    = 15'b001000000000000,
    ST_OLD    = 15'b010000000000000,
    ST_OWAIT  = 15'b100000000000000
  } state_t;

endpackage

FILE: rtl/dlp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for every memory of the DAG longest-path unit. No dependencies.
`timescale 1ns / 1ps

module dlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/dag_longest_path_unit.sv
// Longest-path unit for a weighted directed graph held as an adjacency matrix.
// Depends on dlp_pkg and dlp_ram.
`timescale 1ns / 1ps

// A load request (in_tuser = 0) writes one matrix weight; weight 0 means no
// edge and out-of-range rows or columns are dropped. A run request
// (in_tuser = 1) does a depth-first topological sort, relaxes edges in that
// order and returns VERTICES results, vertex 0 first, tlast on the final one;
// unreachable vertices report -1 and distances saturate at 4194303. in_tready
// is low for the whole run. All work goes through one matrix read port, and
// each result is held until out_tready. After reset the matrix is cleared
// before the first request is taken.

module dag_longest_path_unit #(
  parameter int unsigned VERTICES    = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [5:0] from_vertex, [11:6] to_vertex, [27:12] edge_weight,
  // [33:28] source_vertex, [39:34] zero
  input  logic [39:0] in_tdata,
  // [0] opcode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] vertex_id, [28:6] distance, [31:29] zero
  output logic [31:0] out_tdata,
  // last_result
  output logic        out_tlast
);

  localparam int unsigned VW   = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int unsigned CW   = $clog2(VERTICES + 1);
  localparam int unsigned MD   = VERTICES * VERTICES;
  localparam int unsigned AW   = $clog2(MD);
  localparam int unsigned DB   = dlp_pkg::DIST_BITS;
  localparam int unsigned SUMW = ((WEIGHT_BITS > DB) ? WEIGHT_BITS : DB) + 1;
  localparam int unsigned SW   = VW + CW;

  // Request fields
  logic [5:0]  from_v;
  logic [5:0]  to_v;
  logic [15:0] weight_in;
  logic [5:0]  source_v;
  logic [31:0] weight_ext;

  assign from_v     = in_tdata[5:0];
  assign to_v       = in_tdata[11:6];
  assign weight_in  = in_tdata[27:12];
  assign source_v   = in_tdata[33:28];
  assign weight_ext = {16'd0, weight_in};

  // Control registers
  dlp_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [VERTICES-1:0] visited_r, visited_nxt;
  logic [VERTICES-1:0] dvalid_r, dvalid_nxt;
  logic [CW-1:0]       root_r, root_nxt;
  logic [VW-1:0]       u_r, u_nxt;
  logic [CW-1:0]       c_r, c_nxt;
  logic [CW-1:0]       sp_r, sp_nxt;
  logic [CW-1:0]       npost_r, npost_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [5:0]          src_r, src_nxt;
  logic [DB-1:0]       du_r, du_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [5:0]          ovid_r, ovid_nxt;
  logic [dlp_pkg::OUT_DIST_BITS-1:0] odist_r, odist_nxt;
  logic                olast_r, olast_nxt;

  // Memory ports
  logic                   mat_we;
  logic [AW-1:0]          mat_waddr, mat_raddr;
  logic [WEIGHT_BITS-1:0] mat_wdata, mat_rdata;
  logic                   stk_we;
  logic [VW-1:0]          stk_waddr, stk_raddr;
  logic [SW-1:0]          stk_wdata, stk_rdata;
  logic                   topo_we;
  logic [VW-1:0]          topo_waddr, topo_raddr;
  logic [VW-1:0]          topo_wdata, topo_rdata;
  logic                   dist_we;
  logic [VW-1:0]          dist_waddr, dist_raddr;
  logic [DB-1:0]          dist_wdata, dist_rdata;

  // Relaxation arithmetic
  logic [SUMW-1:0] cand_sum;
  logic [DB-1:0]   cand;
  logic [VW-1:0]   col;

  assign col       = c_r[VW-1:0];
  assign mat_raddr = AW'(AW'(u_r) * AW'(VERTICES) + AW'(col));
  assign stk_raddr = VW'(sp_r - CW'(2));
  assign topo_raddr = VW'(CW'(VERTICES - 1) - i_r);
  assign cand_sum  = SUMW'(du_r) + SUMW'(mat_rdata);
  assign cand      = (cand_sum > SUMW'(dlp_pkg::DIST_MAX)) ? dlp_pkg::DIST_MAX
                                                           : cand_sum[DB-1:0];

  // Distance read address depends on the phase
  always_comb begin
    case (state_r)
      dlp_pkg::ST_RU:  dist_raddr = topo_rdata;
      dlp_pkg::ST_ORD: dist_raddr = i_r[VW-1:0];
      default:         dist_raddr = col;
    endcase
  end

  assign in_tready  = (state_r == dlp_pkg::ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {3'd0, odist_r, ovid_r};
  assign out_tlast  = olast_r;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    visited_nxt = visited_r;
    dvalid_nxt  = dvalid_r;
    root_nxt    = root_r;
    u_nxt       = u_r;
    c_nxt       = c_r;
    sp_nxt      = sp_r;
    npost_nxt   = npost_r;
    i_nxt       = i_r;
    src_nxt     = src_r;
    du_nxt      = du_r;
    ovalid_nxt  = ovalid_r;
    ovid_nxt    = ovid_r;
    odist_nxt   = odist_r;
    olast_nxt   = olast_r;
    mat_we      = 1'b0;
    mat_waddr   = clr_r;
    mat_wdata   = '0;
    stk_we      = 1'b0;
    stk_waddr   = VW'(sp_r - CW'(1));
    stk_wdata   = {u_r, CW'(c_r + CW'(1))};
    topo_we     = 1'b0;
    topo_waddr  = npost_r[VW-1:0];
    topo_wdata  = u_r;
    dist_we     = 1'b0;
    dist_waddr  = col;
    dist_wdata  = cand;

    case (state_r)
      // Zero the matrix after reset
      dlp_pkg::ST_CLR: begin
        mat_we  = 1'b1;
        clr_nxt = AW'(clr_r + AW'(1));
        if (clr_r == AW'(MD - 1)) begin
          state_nxt = dlp_pkg::ST_IDLE;
        end
      end

      dlp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == dlp_pkg::OP_LOAD) begin
            if ({1'b0, from_v} < 7'(VERTICES) && {1'b0, to_v} < 7'(VERTICES)) begin
              mat_we    = 1'b1;
              mat_waddr = AW'(AW'(from_v) * AW'(VERTICES) + AW'(to_v));
              mat_wdata = weight_ext[WEIGHT_BITS-1:0];
            end
          end else begin
            src_nxt     = source_v;
            visited_nxt = '0;
            root_nxt    = '0;
            npost_nxt   = '0;
            state_nxt   = dlp_pkg::ST_DROOT;
          end
        end
      end

      // Next unvisited root of the search
      dlp_pkg::ST_DROOT: begin
        if (root_r == CW'(VERTICES)) begin
          state_nxt = dlp_pkg::ST_RINIT;
        end else if (visited_r[root_r[VW-1:0]]) begin
          root_nxt = CW'(root_r + CW'(1));
        end else begin
          visited_nxt[root_r[VW-1:0]] = 1'b1;
          u_nxt     = root_r[VW-1:0];
          c_nxt     = '0;
          sp_nxt    = CW'(1);
          state_nxt = dlp_pkg::ST_DRD;
        end
      end

      // Scan a column or finish the top vertex
      dlp_pkg::ST_DRD: begin
        if (c_r == CW'(VERTICES)) begin
          topo_we   = 1'b1;
          npost_nxt = CW'(npost_r + CW'(1));
          sp_nxt    = CW'(sp_r - CW'(1));
          if (sp_r == CW'(1)) begin
            root_nxt  = CW'(root_r + CW'(1));
            state_nxt = dlp_pkg::ST_DROOT;
          end else begin
            state_nxt = dlp_pkg::ST_DPOP;
          end
        end else begin
          state_nxt = dlp_pkg::ST_DCHK;
        end
      end

      // Push the neighbor if it is new
      dlp_pkg::ST_DCHK: begin
        c_nxt     = CW'(c_r + CW'(1));
        state_nxt = dlp_pkg::ST_DRD;
        if (!visited_r[col] && mat_rdata != '0 && sp_r < CW'(VERTICES)) begin
          stk_we           = 1'b1;
          visited_nxt[col] = 1'b1;
          u_nxt            = col;
          c_nxt            = '0;
          sp_nxt           = CW'(sp_r + CW'(1));
        end
      end

      // Restore the frame below
      dlp_pkg::ST_DPOP: begin
        u_nxt     = stk_rdata[SW-1:CW];
        c_nxt     = stk_rdata[CW-1:0];
        state_nxt = dlp_pkg::ST_DRD;
      end

      // Seed the source distance
      dlp_pkg::ST_RINIT: begin
        dvalid_nxt = '0;
        if ({1'b0, src_r} < 7'(VERTICES)) begin
          dvalid_nxt[src_r[VW-1:0]] = 1'b1;
          dist_we    = 1'b1;
          dist_waddr = src_r[VW-1:0];
          dist_wdata = '0;
        end
        i_nxt     = '0;
        state_nxt = dlp_pkg::ST_RTOPO;
      end

      dlp_pkg::ST_RTOPO: begin
        if (i_r == CW'(VERTICES)) begin
          i_nxt     = '0;
          state_nxt = dlp_pkg::ST_ORD;
        end else begin
          state_nxt = dlp_pkg::ST_RU;
        end
      end

      // Vertex at this order position; skip it when unreachable
      dlp_pkg::ST_RU: begin
        u_nxt = topo_rdata;
        if (dvalid_r[topo_rdata]) begin
          state_nxt = dlp_pkg::ST_RDU;
        end else begin
          i_nxt     = CW'(i_r + CW'(1));
          state_nxt = dlp_pkg::ST_RTOPO;
        end
      end

      dlp_pkg::ST_RDU: begin
        du_nxt    = dist_rdata;
        c_nxt     = '0;
        state_nxt = dlp_pkg::ST_RRD;
      end

      dlp_pkg::ST_RRD: begin
        if (c_r == CW'(VERTICES)) begin
          i_nxt     = CW'(i_r + CW'(1));
          state_nxt = dlp_pkg::ST_RTOPO;
        end else begin
          state_nxt = dlp_pkg::ST_RCHK;
        end
      end

      // Relax one edge, keeping the greater distance
      dlp_pkg::ST_RCHK: begin
        c_nxt     = CW'(c_r + CW'(1));
        state_nxt = dlp_pkg::ST_RRD;
        if (mat_rdata != '0 && (!dvalid_r[col] || cand > dist_rdata)) begin
          dist_we         = 1'b1;
          dvalid_nxt[col] = 1'b1;
          if (col == u_r) begin
            du_nxt = cand;
          end
        end
      end

      dlp_pkg::ST_ORD: begin
        state_nxt = dlp_pkg::ST_OLD;
      end

      dlp_pkg::ST_OLD: begin
        ovalid_nxt = 1'b1;
        ovid_nxt   = 6'(i_r);
        odist_nxt  = dvalid_r[i_r[VW-1:0]] ? {1'b0, dist_rdata} : dlp_pkg::DIST_NONE;
        olast_nxt  = (i_r == CW'(VERTICES - 1));
        state_nxt  = dlp_pkg::ST_OWAIT;
      end

      dlp_pkg::ST_OWAIT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = dlp_pkg::ST_IDLE;
          end else begin
            i_nxt     = CW'(i_r + CW'(1));
            state_nxt = dlp_pkg::ST_ORD;
          end
        end
      end

      default: begin
        state_nxt = dlp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dlp_pkg::ST_CLR;
      clr_r     <= '0;
      visited_r <= '0;
      dvalid_r  <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      visited_r <= visited_nxt;
      dvalid_r  <= dvalid_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    root_r  <= root_nxt;
    u_r     <= u_nxt;
    c_r     <= c_nxt;
    sp_r    <= sp_nxt;
    npost_r <= npost_nxt;
    i_r     <= i_nxt;
    src_r   <= src_nxt;
    du_r    <= du_nxt;
    ovid_r  <= ovid_nxt;
    odist_r <= odist_nxt;
    olast_r <= olast_nxt;
  end

  // Adjacency matrix
  dlp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MD)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rdata)
  );

  // Search stack: vertex and next column of each lower frame
  dlp_ram #(.WIDTH(SW), .DEPTH(VERTICES)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Finishing order of the search
  dlp_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_topo (
    .clk(clk), .we(topo_we), .waddr(topo_waddr), .wdata(topo_wdata),
    .raddr(topo_raddr), .rdata(topo_rdata)
  );

  // Distances
  dlp_ram #(.WIDTH(DB), .DEPTH(VERTICES)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

endmodule
